// ===== sv/assert_macros.svh =====
// Assertion shorthands used by the checker of this project.
// Every check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFA_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/vfa_pkg.sv =====
package vfa_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// Full-width products, sums of three products, and rounded values.
	localparam int PROD_W = 2 * WORD_BITS;
	localparam int SUM_W  = PROD_W + 2;
	localparam int RND_W  = SUM_W - FRAC_BITS;
	localparam int HALF   = 1 << (FRAC_BITS - 1);

	// Square root and divide datapaths.
	localparam int ROOT_W = WORD_BITS;
	localparam int QUO_W  = FRAC_BITS + 2;
	localparam int DREM_W = WORD_BITS + 2;
	localparam int NUM_W  = WORD_BITS + FRAC_BITS + 2;

	localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_SCALE = 3'd2,
		OP_DOT   = 3'd3,
		OP_CROSS = 3'd4,
		OP_MAG   = 3'd5,
		OP_NORM  = 3'd6
	} vfa_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} vfa_status_t;

	typedef struct packed {
		logic [2:0]                  req_type;
		logic signed [WORD_BITS-1:0] ax;
		logic signed [WORD_BITS-1:0] ay;
		logic signed [WORD_BITS-1:0] az;
		logic signed [WORD_BITS-1:0] bx;
		logic signed [WORD_BITS-1:0] by;
		logic signed [WORD_BITS-1:0] bz;
		logic signed [WORD_BITS-1:0] scalar_in;
	} vfa_req_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] rx;
		logic signed [WORD_BITS-1:0] ry;
		logic signed [WORD_BITS-1:0] rz;
		logic signed [WORD_BITS-1:0] scalar_out;
		logic [1:0]                  status;
	} vfa_rsp_t;

	// What an item carries past the multiply front end.
	typedef struct packed {
		logic [2:0]                 op;
		vfa_rsp_t                   rsp;
		logic [2:0]                 neg;
		logic [2:0][WORD_BITS-1:0]  aabs;
	} vfa_side_t;

	typedef struct packed {
		logic [PROD_W-1:0] rad;
		logic [ROOT_W:0]   rem;
		logic [ROOT_W-1:0] root;
	} vfa_sqrt_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [QUO_W-1:0]  nb;
		logic [QUO_W-1:0]  q;
	} vfa_div_t;

	typedef struct packed {
		logic                        ov;
		logic signed [WORD_BITS-1:0] val;
	} vfa_sat_t;

	function automatic vfa_sat_t vfa_sat(input logic signed [RND_W-1:0] v);
		vfa_sat_t r;
		r.ov  = 1'b0;
		r.val = WORD_BITS'(v);
		if (v > RND_W'(SMAX)) begin
			r.ov  = 1'b1;
			r.val = SMAX;
		end else if (v < RND_W'(SMIN)) begin
			r.ov  = 1'b1;
			r.val = SMIN;
		end
		return r;
	endfunction

endpackage

// ===== sv/vfa_front.sv =====
module vfa_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          req_valid,
	input  vfa_pkg::vfa_req_t             req,
	output logic                          valid_s4,
	output vfa_pkg::vfa_side_t            side_s4,
	output logic [vfa_pkg::PROD_W-1:0]    sq_s4
);
	import vfa_pkg::*;

	logic                        valid_s1, valid_s2, valid_s3;
	vfa_req_t                    req_s1, req_s2, req_s3;
	logic signed [PROD_W-1:0]    prod_s2 [6];
	logic signed [WORD_BITS:0]   ab_s2 [3];
	logic signed [SUM_W-1:0]     wide_s3 [3];

	logic signed [WORD_BITS-1:0] lhs [6];
	logic signed [WORD_BITS-1:0] rhs [6];
	logic signed [WORD_BITS:0]   ab_d [3];
	logic signed [SUM_W-1:0]     wide_d [3];
	logic signed [SUM_W-1:0]     rs [3];
	logic signed [RND_W-1:0]     rd [3];
	vfa_sat_t                    st [3];
	vfa_side_t                   side_d;

	// Operands: cross uses all six multipliers, scale/dot/mag/norm use 0, 2, 4.
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			lhs[i] = '0;
			rhs[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			ab_d[i] = '0;
		end
		case (req_s1.req_type)
			OP_ADD: begin
				ab_d[0] = (WORD_BITS + 1)'(req_s1.ax) + (WORD_BITS + 1)'(req_s1.bx);
				ab_d[1] = (WORD_BITS + 1)'(req_s1.ay) + (WORD_BITS + 1)'(req_s1.by);
				ab_d[2] = (WORD_BITS + 1)'(req_s1.az) + (WORD_BITS + 1)'(req_s1.bz);
			end
			OP_SUB: begin
				ab_d[0] = (WORD_BITS + 1)'(req_s1.ax) - (WORD_BITS + 1)'(req_s1.bx);
				ab_d[1] = (WORD_BITS + 1)'(req_s1.ay) - (WORD_BITS + 1)'(req_s1.by);
				ab_d[2] = (WORD_BITS + 1)'(req_s1.az) - (WORD_BITS + 1)'(req_s1.bz);
			end
			OP_SCALE: begin
				lhs[0] = req_s1.ax; rhs[0] = req_s1.scalar_in;
				lhs[2] = req_s1.ay; rhs[2] = req_s1.scalar_in;
				lhs[4] = req_s1.az; rhs[4] = req_s1.scalar_in;
			end
			OP_DOT: begin
				lhs[0] = req_s1.ax; rhs[0] = req_s1.bx;
				lhs[2] = req_s1.ay; rhs[2] = req_s1.by;
				lhs[4] = req_s1.az; rhs[4] = req_s1.bz;
			end
			OP_CROSS: begin
				lhs[0] = req_s1.ay; rhs[0] = req_s1.bz;
				lhs[1] = req_s1.az; rhs[1] = req_s1.by;
				lhs[2] = req_s1.az; rhs[2] = req_s1.bx;
				lhs[3] = req_s1.ax; rhs[3] = req_s1.bz;
				lhs[4] = req_s1.ax; rhs[4] = req_s1.by;
				lhs[5] = req_s1.ay; rhs[5] = req_s1.bx;
			end
			OP_MAG, OP_NORM: begin
				lhs[0] = req_s1.ax; rhs[0] = req_s1.ax;
				lhs[2] = req_s1.ay; rhs[2] = req_s1.ay;
				lhs[4] = req_s1.az; rhs[4] = req_s1.az;
			end
			default: begin
			end
		endcase
	end

	// Every operation is brought to double scale so that one rounding serves all.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide_d[i] = '0;
		end
		case (req_s2.req_type)
			OP_ADD, OP_SUB: begin
				for (int i = 0; i < 3; i++) begin
					wide_d[i] = SUM_W'(ab_s2[i]) << FRAC_BITS;
				end
			end
			OP_SCALE: begin
				wide_d[0] = SUM_W'(prod_s2[0]);
				wide_d[1] = SUM_W'(prod_s2[2]);
				wide_d[2] = SUM_W'(prod_s2[4]);
			end
			OP_CROSS: begin
				wide_d[0] = SUM_W'(prod_s2[0]) - SUM_W'(prod_s2[1]);
				wide_d[1] = SUM_W'(prod_s2[2]) - SUM_W'(prod_s2[3]);
				wide_d[2] = SUM_W'(prod_s2[4]) - SUM_W'(prod_s2[5]);
			end
			OP_DOT, OP_MAG, OP_NORM: begin
				wide_d[0] = SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[2]) + SUM_W'(prod_s2[4]);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rs[i] = wide_s3[i] + SUM_W'(HALF);
			rd[i] = RND_W'(rs[i] >>> FRAC_BITS);
			st[i] = vfa_sat(rd[i]);
		end
		side_d            = '0;
		side_d.op         = req_s3.req_type;
		side_d.rsp.status = ST_OK;
		side_d.neg        = {req_s3.az[WORD_BITS-1], req_s3.ay[WORD_BITS-1],
			req_s3.ax[WORD_BITS-1]};
		side_d.aabs[0] = req_s3.ax[WORD_BITS-1] ? WORD_BITS'(-req_s3.ax) : WORD_BITS'(req_s3.ax);
		side_d.aabs[1] = req_s3.ay[WORD_BITS-1] ? WORD_BITS'(-req_s3.ay) : WORD_BITS'(req_s3.ay);
		side_d.aabs[2] = req_s3.az[WORD_BITS-1] ? WORD_BITS'(-req_s3.az) : WORD_BITS'(req_s3.az);
		case (req_s3.req_type)
			OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
				side_d.rsp.rx = st[0].val;
				side_d.rsp.ry = st[1].val;
				side_d.rsp.rz = st[2].val;
				if (st[0].ov || st[1].ov || st[2].ov) begin
					side_d.rsp.status = ST_SAT;
				end
			end
			OP_DOT: begin
				side_d.rsp.scalar_out = st[0].val;
				if (st[0].ov) begin
					side_d.rsp.status = ST_SAT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req;
			req_s2 <= req_s1;
			req_s3 <= req_s2;
			for (int i = 0; i < 6; i++) begin
				prod_s2[i] <= lhs[i] * rhs[i];
			end
			for (int i = 0; i < 3; i++) begin
				ab_s2[i]   <= ab_d[i];
				wide_s3[i] <= wide_d[i];
			end
			side_s4 <= side_d;
			sq_s4   <= wide_s3[0][PROD_W-1:0];
		end
	end

endmodule

// ===== sv/vfa_sqrt_step.sv =====
module vfa_sqrt_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 valid_i,
	input  vfa_pkg::vfa_side_t   side_i,
	input  vfa_pkg::vfa_sqrt_t   sqrt_i,
	output logic                 valid_s1,
	output vfa_pkg::vfa_side_t   side_s1,
	output vfa_pkg::vfa_sqrt_t   sqrt_s1
);
	import vfa_pkg::*;

	logic [ROOT_W+2:0] cur;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] diff;
	logic              ge;
	vfa_sqrt_t         nxt;

	// One result bit per stage: bring down two radicand bits, try root*4+1.
	always_comb begin
		cur       = {sqrt_i.rem, sqrt_i.rad[PROD_W-1 -: 2]};
		trial     = {1'b0, sqrt_i.root, 2'b01};
		diff      = cur - trial;
		ge        = (cur >= trial);
		nxt.rad   = {sqrt_i.rad[PROD_W-3:0], 2'b00};
		nxt.rem   = ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
		nxt.root  = {sqrt_i.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_i;
			sqrt_s1 <= nxt;
		end
	end

endmodule

// ===== sv/vfa_div_step.sv =====
module vfa_div_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              valid_i,
	input  vfa_pkg::vfa_side_t                side_i,
	input  logic [vfa_pkg::DREM_W-1:0]        dsor_i,
	input  vfa_pkg::vfa_div_t [2:0]           lanes_i,
	output logic                              valid_s1,
	output vfa_pkg::vfa_side_t                side_s1,
	output logic [vfa_pkg::DREM_W-1:0]        dsor_s1,
	output vfa_pkg::vfa_div_t [2:0]           lanes_s1
);
	import vfa_pkg::*;

	logic [DREM_W:0]    cur [3];
	logic [DREM_W:0]    diff [3];
	logic [2:0]         ge;
	vfa_div_t [2:0]     nxt;

	// Restoring division, one quotient bit per stage in each of the three lanes.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cur[i]      = {lanes_i[i].rem, lanes_i[i].nb[QUO_W-1]};
			diff[i]     = cur[i] - {1'b0, dsor_i};
			ge[i]       = (cur[i] >= {1'b0, dsor_i});
			nxt[i].rem  = ge[i] ? diff[i][DREM_W-1:0] : cur[i][DREM_W-1:0];
			nxt[i].nb   = {lanes_i[i].nb[QUO_W-2:0], 1'b0};
			nxt[i].q    = {lanes_i[i].q[QUO_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1  <= side_i;
			dsor_s1  <= dsor_i;
			lanes_s1 <= nxt;
		end
	end

endmodule

// ===== sv/vector3_fixed_point_alu_core.sv =====
// Fixed-point 3D vector unit (signed Q16.16): add, subtract, scale, dot, cross, magnitude
// and normalize, with every result saturated and flagged. It takes one item per cycle and
// returns one result per item, in order. Every item passes through the same pipeline of
// 4 + ROOT_W + 2 + QUO_W + 1 register stages, most of them in the one-bit-per-stage square
// root (32 stages) and the one-bit-per-stage divider for normalize (18 stages). The whole
// pipeline holds while a result waits under rsp_stall, and req_stall is raised in exactly
// those cycles.
module vector3_fixed_point_alu_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  vfa_pkg::vfa_req_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output vfa_pkg::vfa_rsp_t  rsp
);
	import vfa_pkg::*;

	logic adv;

	logic           valid_sq [ROOT_W+1];
	vfa_side_t      side_sq  [ROOT_W+1];
	vfa_sqrt_t      sqs      [ROOT_W+1];
	logic [PROD_W-1:0] sq_in;

	logic           valid_dv [QUO_W+1];
	vfa_side_t      side_dv  [QUO_W+1];
	logic [DREM_W-1:0] dsor_dv [QUO_W+1];
	vfa_div_t [2:0] lanes_dv [QUO_W+1];

	// Back-end stages: rounding of the root, divider setup, output register.
	logic              valid_rnd_s1;
	vfa_side_t         side_rnd_s1;
	logic [ROOT_W:0]   root_rnd_s1;
	logic              valid_set_s2;
	vfa_side_t         side_set_s2;
	logic [DREM_W-1:0] dsor_set_s2;
	vfa_div_t [2:0]    lanes_set_s2;
	logic              valid_out_s3;
	vfa_rsp_t          rsp_out_s3;

	logic [ROOT_W:0]   root_d;
	vfa_side_t         side_set_d;
	vfa_div_t [2:0]    lanes_d;
	logic [NUM_W-1:0]  num [3];
	vfa_sat_t          mag_sat;
	logic signed [WORD_BITS-1:0] qv [3];
	vfa_rsp_t          rsp_d;

	assign adv       = !(valid_out_s3 && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = valid_out_s3;
	assign rsp       = rsp_out_s3;

	vfa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.req_valid(req_valid),
		.req      (req),
		.valid_s4 (valid_sq[0]),
		.side_s4  (side_sq[0]),
		.sq_s4    (sq_in)
	);

	assign sqs[0] = '{rad: sq_in, rem: '0, root: '0};

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		vfa_sqrt_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.valid_i (valid_sq[k]),
			.side_i  (side_sq[k]),
			.sqrt_i  (sqs[k]),
			.valid_s1(valid_sq[k+1]),
			.side_s1 (side_sq[k+1]),
			.sqrt_s1 (sqs[k+1])
		);
	end

	// Round the root to nearest: the remainder exceeds the root exactly when
	// the true root lies at or above the half point.
	always_comb begin
		root_d = {1'b0, sqs[ROOT_W].root};
		if (sqs[ROOT_W].rem > {1'b0, sqs[ROOT_W].root}) begin
			root_d = root_d + 1'b1;
		end
	end

	always_comb begin
		side_set_d = side_rnd_s1;
		mag_sat    = vfa_sat(RND_W'({1'b0, root_rnd_s1}));
		if (side_rnd_s1.op == OP_MAG) begin
			side_set_d.rsp.scalar_out = mag_sat.val;
			side_set_d.rsp.status     = mag_sat.ov ? ST_SAT : ST_OK;
		end else if (side_rnd_s1.op == OP_NORM && root_rnd_s1 == '0) begin
			side_set_d.rsp.status = ST_ZERO;
		end
		// Quotient of (2|a|*2^F + r) / 2r rounds |a|*2^F / r half away from zero.
		for (int i = 0; i < 3; i++) begin
			num[i] = NUM_W'({side_rnd_s1.aabs[i], {(FRAC_BITS + 1){1'b0}}})
				+ NUM_W'(root_rnd_s1);
			lanes_d[i].rem = DREM_W'(num[i][NUM_W-1:QUO_W]);
			lanes_d[i].nb  = num[i][QUO_W-1:0];
			lanes_d[i].q   = '0;
		end
	end

	assign valid_dv[0] = valid_set_s2;
	assign side_dv[0]  = side_set_s2;
	assign dsor_dv[0]  = dsor_set_s2;
	assign lanes_dv[0] = lanes_set_s2;

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		vfa_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.valid_i (valid_dv[k]),
			.side_i  (side_dv[k]),
			.dsor_i  (dsor_dv[k]),
			.lanes_i (lanes_dv[k]),
			.valid_s1(valid_dv[k+1]),
			.side_s1 (side_dv[k+1]),
			.dsor_s1 (dsor_dv[k+1]),
			.lanes_s1(lanes_dv[k+1])
		);
	end

	always_comb begin
		rsp_d = side_dv[QUO_W].rsp;
		for (int i = 0; i < 3; i++) begin
			qv[i] = {{(WORD_BITS - QUO_W){1'b0}}, lanes_dv[QUO_W][i].q};
			if (side_dv[QUO_W].neg[i]) begin
				qv[i] = -qv[i];
			end
		end
		if (side_dv[QUO_W].op == OP_NORM && side_dv[QUO_W].rsp.status == ST_OK) begin
			rsp_d.rx = qv[0];
			rsp_d.ry = qv[1];
			rsp_d.rz = qv[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_rnd_s1 <= 1'b0;
			valid_set_s2 <= 1'b0;
			valid_out_s3 <= 1'b0;
		end else if (adv) begin
			valid_rnd_s1 <= valid_sq[ROOT_W];
			valid_set_s2 <= valid_rnd_s1;
			valid_out_s3 <= valid_dv[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_rnd_s1  <= side_sq[ROOT_W];
			root_rnd_s1  <= root_d;
			side_set_s2  <= side_set_d;
			dsor_set_s2  <= {root_rnd_s1, 1'b0};
			lanes_set_s2 <= lanes_d;
			rsp_out_s3   <= rsp_d;
		end
	end

endmodule

// ===== sv/vfa_checker.sv =====
`include "assert_macros.svh"

module vfa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input vfa_pkg::vfa_rsp_t  rsp
);
	import vfa_pkg::*;

	`VFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result item changed while stalled")

	// The pipeline only backs up when a finished result is held at the output.
	`VFA_ASSERT(a_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled without an output stall")

	`VFA_ASSERT(a_zero_norm, rsp_valid && rsp.status == ST_ZERO, rsp.rx == 0 && rsp.ry == 0 && rsp.rz == 0 && rsp.scalar_out == 0, "zero-vector normalize returned nonzero fields")

	`VFA_ASSERT(a_kind, rsp_valid, rsp.scalar_out == 0 || (rsp.rx == 0 && rsp.ry == 0 && rsp.rz == 0), "result has both vector and scalar parts")

endmodule

bind vector3_fixed_point_alu_core vfa_checker u_vfa_checker (.*);

// ===== verif/vector3_fixed_point_alu_core_tb.sv =====
module vector3_fixed_point_alu_core_tb;
	import vfa_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PER_PHASE   = 275;

	typedef struct {
		vfa_req_t q;
		bit       typed;
		vfa_rsp_t want;
	} dir_row_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	vfa_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	vfa_rsp_t rsp;

	vfa_rsp_t pending_rsp[$];
	dir_row_t dir_rows[$];
	int       err_cnt;
	int       accepted_reqs;
	int       quiet_cycles;
	int       send_idle_pct;
	int       recv_stall_pct;
	bit       cur_typed;
	vfa_rsp_t cur_want;

	vector3_fixed_point_alu_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [67:0] round_q(input logic signed [67:0] x);
		logic signed [67:0] h;
		h = 68'sd1 <<< (FRAC_BITS - 1);
		return (x + h) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [WORD_BITS-1:0] clamp_word(input logic signed [67:0] x,
			inout bit ov);
		logic signed [67:0] hi;
		logic signed [67:0] lo;
		hi = SMAX;
		lo = SMIN;
		if (x > hi) begin
			ov = 1'b1;
			return SMAX;
		end
		if (x < lo) begin
			ov = 1'b1;
			return SMIN;
		end
		return x[WORD_BITS-1:0];
	endfunction

	// Expected result of one vector item, from exact wide arithmetic.
	function automatic vfa_rsp_t vector_result(input vfa_req_t q);
		logic signed [67:0] a[3];
		logic signed [67:0] b[3];
		logic signed [67:0] s;
		logic signed [67:0] v[4];
		logic signed [67:0] sum_sq;
		logic [63:0] sq;
		logic [63:0] root;
		logic [63:0] probe;
		logic [63:0] n;
		logic [63:0] quo;
		bit ov;
		vfa_rsp_t r;
		a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
		b[0] = q.bx; b[1] = q.by; b[2] = q.bz;
		s = q.scalar_in;
		foreach (v[i]) v[i] = 0;
		ov = 1'b0;
		r = '0;
		r.status = ST_OK;
		case (q.req_type)
			OP_ADD: begin
				for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
			end
			OP_SUB: begin
				for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) v[i] = round_q(a[i] * s);
			end
			OP_DOT: v[3] = round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
			OP_CROSS: begin
				v[0] = round_q(a[1] * b[2] - a[2] * b[1]);
				v[1] = round_q(a[2] * b[0] - a[0] * b[2]);
				v[2] = round_q(a[0] * b[1] - a[1] * b[0]);
			end
			OP_MAG, OP_NORM: begin
				sum_sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
				sq = sum_sq[63:0];
				root = 0;
				probe = 64'd1 << 62;
				while (probe > sq) probe = probe >> 2;
				while (probe != 0) begin
					if (sq >= root + probe) begin
						sq = sq - (root + probe);
						root = (root >> 1) + probe;
					end else begin
						root = root >> 1;
					end
					probe = probe >> 2;
				end
				// sq now holds the remainder of the integer root.
				if (sq > root) root = root + 1;
				if (q.req_type == OP_MAG) begin
					v[3] = $signed({4'b0, root});
				end else if (root == 0) begin
					r.status = ST_ZERO;
				end else begin
					for (int i = 0; i < 3; i++) begin
						n = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
						n = n << FRAC_BITS;
						quo = (2 * n + root) / (2 * root);
						v[i] = (a[i] < 0) ? -$signed({4'b0, quo}) : $signed({4'b0, quo});
					end
				end
			end
			default: ;
		endcase
		r.rx = clamp_word(v[0], ov);
		r.ry = clamp_word(v[1], ov);
		r.rz = clamp_word(v[2], ov);
		r.scalar_out = clamp_word(v[3], ov);
		if (ov && r.status == ST_OK) r.status = ST_SAT;
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return SMAX;
			1: return SMIN;
			2: return '0;
			3: return WORD_BITS'($urandom_range(0, 1 << 21)) - WORD_BITS'(1 << 20);
			4: return WORD_BITS'($signed($urandom)) >>> $urandom_range(4, 14);
			default: return $urandom;
		endcase
	endfunction

	function automatic vfa_req_t random_req();
		vfa_req_t q;
		q.req_type = ($urandom_range(0, 30) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
		q.ax = pick_word(); q.ay = pick_word(); q.az = pick_word();
		q.bx = pick_word(); q.by = pick_word(); q.bz = pick_word();
		q.scalar_in = pick_word();
		return q;
	endfunction

	function automatic vfa_req_t make_req(input logic [2:0] op,
			input logic signed [WORD_BITS-1:0] x, input logic signed [WORD_BITS-1:0] y,
			input logic signed [WORD_BITS-1:0] z, input logic signed [WORD_BITS-1:0] s);
		vfa_req_t q;
		q.req_type = op;
		q.ax = x; q.ay = y; q.az = z;
		q.bx = x; q.by = y; q.bz = z;
		q.scalar_in = s;
		return q;
	endfunction

	function automatic vfa_rsp_t make_rsp(input logic signed [WORD_BITS-1:0] x,
			input logic signed [WORD_BITS-1:0] y, input logic signed [WORD_BITS-1:0] z,
			input logic signed [WORD_BITS-1:0] s, input vfa_status_t st);
		vfa_rsp_t r;
		r.rx = x; r.ry = y; r.rz = z; r.scalar_out = s; r.status = st;
		return r;
	endfunction

	task automatic add_row(input vfa_req_t q, input bit typed, input vfa_rsp_t want);
		dir_row_t row;
		row.q = q;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// Presents one item and holds it until it has been taken.
	task automatic send_item(input vfa_req_t q, input bit typed, input vfa_rsp_t want);
		int seen;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= q;
		req_valid <= 1'b1;
		cur_typed = typed;
		cur_want = want;
		seen = accepted_reqs;
		@(negedge clk);
		while (accepted_reqs == seen) @(negedge clk);
	endtask

	always @(negedge clk) rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	always @(posedge clk) begin
		vfa_rsp_t exp_rsp;
		bit moved;
		moved = 1'b0;
		if (arst_n && req_valid && !req_stall) begin
			pending_rsp.push_back(cur_typed ? cur_want : vector_result(req));
			accepted_reqs++;
			moved = 1'b1;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			moved = 1'b1;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result %h", $time, rsp);
				err_cnt++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp.rx !== exp_rsp.rx)
					$display("%0t: rx expected %h actual %h", $time, exp_rsp.rx, rsp.rx);
				if (rsp.ry !== exp_rsp.ry)
					$display("%0t: ry expected %h actual %h", $time, exp_rsp.ry, rsp.ry);
				if (rsp.rz !== exp_rsp.rz)
					$display("%0t: rz expected %h actual %h", $time, exp_rsp.rz, rsp.rz);
				if (rsp.scalar_out !== exp_rsp.scalar_out)
					$display("%0t: scalar_out expected %h actual %h", $time,
						exp_rsp.scalar_out, rsp.scalar_out);
				if (rsp.status !== exp_rsp.status)
					$display("%0t: status expected %0d actual %0d", $time,
						exp_rsp.status, rsp.status);
				if (rsp !== exp_rsp) err_cnt++;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		vfa_rsp_t none;
		logic signed [WORD_BITS-1:0] one_q;
		err_cnt = 0;
		accepted_reqs = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_typed = 1'b0;
		cur_want = '0;
		none = '0;
		one_q = 1 << FRAC_BITS;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;

		add_row(make_req(OP_ADD, SMAX, SMAX, SMAX, 0), 1,
			make_rsp(SMAX, SMAX, SMAX, 0, ST_SAT));
		add_row(make_req(OP_ADD, SMIN, SMIN, SMIN, 0), 1,
			make_rsp(SMIN, SMIN, SMIN, 0, ST_SAT));
		add_row(make_req(OP_ADD, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, ST_OK));
		add_row(make_req(OP_SUB, SMIN, 0, SMAX, 0), 1, make_rsp(0, 0, 0, 0, ST_OK));
		add_row(make_req(OP_SCALE, SMAX, SMIN, one_q, SMAX), 0, none);
		add_row(make_req(OP_SCALE, SMIN, 3, -3, 32'sh0000_8000), 0, none);
		add_row(make_req(OP_SCALE, one_q, -one_q, 7, one_q), 0, none);
		add_row(make_req(OP_DOT, SMIN, SMIN, SMIN, 0), 1, make_rsp(0, 0, 0, SMAX, ST_SAT));
		add_row(make_req(OP_DOT, one_q, 2 * one_q, 3 * one_q, 0), 1,
			make_rsp(0, 0, 0, 14 * one_q, ST_OK));
		add_row(make_req(OP_CROSS, SMAX, SMIN, 5, 0), 0, none);
		add_row(make_req(OP_MAG, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, ST_OK));
		add_row(make_req(OP_MAG, SMIN, SMIN, SMIN, 0), 1, make_rsp(0, 0, 0, SMAX, ST_SAT));
		add_row(make_req(OP_MAG, 3 * one_q, 4 * one_q, 0, 0), 1,
			make_rsp(0, 0, 0, 5 * one_q, ST_OK));
		add_row(make_req(OP_MAG, 1, 1, 1, 0), 0, none);
		add_row(make_req(OP_NORM, 0, 0, 0, SMAX), 1, make_rsp(0, 0, 0, 0, ST_ZERO));
		add_row(make_req(OP_NORM, 0, -5 * one_q, 0, 0), 1,
			make_rsp(0, -one_q, 0, 0, ST_OK));
		add_row(make_req(OP_NORM, SMIN, SMAX, 1, 0), 0, none);
		add_row(make_req(OP_NORM, 1, 0, 0, 0), 0, none);
		add_row(make_req(3'd7, SMAX, SMIN, SMAX, SMIN), 1, none);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].want);
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			for (int k = 0; k < PER_PHASE; k++) send_item(random_req(), 0, none);
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
